// ===== src/ipt_pkg.sv =====
// Shared constants and types for the inverted page table lookup block.
// No dependencies; compile first.
`default_nettype none

package ipt_pkg;

  localparam int PID_W     = 16;
  localparam int VPAGE_W   = 20;
  localparam int OFF_W     = 12;
  localparam int VA_W      = 32;
  localparam int PA_W      = 18;
  localparam int IDX_IN_W  = 6;
  localparam int CFG_W     = 7;

  localparam int DEF_TABLE_ENTRIES = 64;

  // item opcodes carried in the mode field
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_XLATE = 1'b1;

  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [VPAGE_W-1:0] vpage;
  } ipt_entry_t;

  // table port strobes from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ipt_mem_ctl_t;

endpackage

`default_nettype wire

// ===== src/ipt_ifs.sv =====
// Channel interfaces: request, result and configuration write.
// Depends on ipt_pkg.
`default_nettype none

interface ipt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [ipt_pkg::IDX_IN_W-1:0] entry_index;
  logic [ipt_pkg::PID_W-1:0]    entry_pid;
  logic [ipt_pkg::VPAGE_W-1:0]  entry_vpage;
  logic [ipt_pkg::VA_W-1:0]     virtual_address;
  logic [ipt_pkg::PID_W-1:0]    current_pid;

  modport source (output valid, mode, entry_index, entry_pid, entry_vpage,
                  virtual_address, current_pid, input ready);
  modport sink   (input valid, mode, entry_index, entry_pid, entry_vpage,
                  virtual_address, current_pid, output ready);
endinterface

interface ipt_out_if;
  logic                     valid;
  logic                     ready;
  logic [ipt_pkg::PA_W-1:0] physical_address;
  logic                     hit;

  modport source (output valid, physical_address, hit, input ready);
  modport sink   (input valid, physical_address, hit, output ready);
endinterface

interface ipt_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [ipt_pkg::CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== src/ipt_table.sv =====
// Page table storage: one write port, one read port, registered read data.
// Depends on ipt_pkg.
`default_nettype none

module ipt_table #(
  parameter int  DEPTH = ipt_pkg::DEF_TABLE_ENTRIES,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                   clk,
  input  ipt_pkg::ipt_mem_ctl_t ctl,
  input  wire [AW-1:0]          wr_addr,
  input  ipt_pkg::ipt_entry_t   wr_data,
  input  wire [AW-1:0]          rd_addr,
  output ipt_pkg::ipt_entry_t   rd_data_r
);
  import ipt_pkg::*;

  ipt_entry_t ent_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      ent_mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= ent_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/ipt_ctrl.sv =====
// Lookup sequencer: table loads, linear search over the table, result register.
// Depends on ipt_pkg and ipt_ifs; drives ipt_table.
`default_nettype none

module ipt_ctrl #(
  parameter int  TABLE_ENTRIES = ipt_pkg::DEF_TABLE_ENTRIES,
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire                       clk,
  input  wire                       rst_n,
  ipt_in_if.sink                    in_ch,
  ipt_out_if.source                 out_ch,
  input  wire [ipt_pkg::CFG_W-1:0]  entries_in_use,
  output ipt_pkg::ipt_mem_ctl_t     mem_ctl,
  output logic [IDX_W-1:0]          wr_addr,
  output ipt_pkg::ipt_entry_t       wr_data,
  output logic [IDX_W-1:0]          rd_addr,
  input  ipt_pkg::ipt_entry_t       rd_data
);
  import ipt_pkg::*;

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int LD_W  = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

  state_t             state_r;
  logic [PID_W-1:0]   pid_r;
  logic [VPAGE_W-1:0] vpage_r;
  logic [OFF_W-1:0]   off_r;
  logic [CNT_W-1:0]   lim_r;
  logic [CNT_W-1:0]   iss_r;
  logic               cmp_vld_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic               res_hit_r;
  logic [IDX_W-1:0]   res_idx_r;
  logic               out_valid_r;
  logic [PA_W-1:0]    pa_r;
  logic               hit_r;

  logic               in_fire;
  logic               ld_ok;
  logic               match;
  logic               rd_go;
  logic               search_end;
  logic               out_free;
  logic               out_valid_nxt;
  logic [CNT_W-1:0]   lim_nxt;

  always_comb begin
    in_fire        = in_ch.valid && in_ch.ready;
    ld_ok          = LD_W'(in_ch.entry_index) < LD_W'(TABLE_ENTRIES);
    mem_ctl.wr_en  = in_fire && (in_ch.mode == MODE_LOAD) && ld_ok;
    wr_addr        = IDX_W'(in_ch.entry_index);
    wr_data.pid    = in_ch.entry_pid;
    wr_data.vpage  = in_ch.entry_vpage;

    match      = cmp_vld_r && (rd_data.pid == pid_r) && (rd_data.vpage == vpage_r);
    rd_go      = (state_r == ST_SEARCH) && (iss_r < lim_r) && !match;
    search_end = (state_r == ST_SEARCH) && (match || (!cmp_vld_r && (iss_r == lim_r)));
    mem_ctl.rd_en = rd_go;
    rd_addr       = iss_r[IDX_W-1:0];

    // count above the table size searches the whole table
    lim_nxt = (CMP_W'(entries_in_use) > CMP_W'(TABLE_ENTRIES)) ?
              CNT_W'(TABLE_ENTRIES) : CNT_W'(entries_in_use);

    out_free = !out_valid_r || out_ch.ready;
    // load a new result when done, otherwise hold until the sink takes it
    out_valid_nxt = ((state_r == ST_DONE) && out_free) || (out_valid_r && !out_ch.ready);

    in_ch.ready             = (state_r == ST_IDLE);
    out_ch.valid            = out_valid_r;
    out_ch.physical_address = pa_r;
    out_ch.hit              = hit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_IDLE: begin
          cmp_vld_r <= 1'b0;
          if (in_fire && (in_ch.mode == MODE_XLATE)) begin
            pid_r   <= in_ch.current_pid;
            vpage_r <= in_ch.virtual_address[VA_W-1:OFF_W];
            off_r   <= in_ch.virtual_address[OFF_W-1:0];
            lim_r   <= lim_nxt;
            iss_r   <= '0;
            state_r <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          // rd_go is low whenever the search ends, so the compare stage drains
          cmp_vld_r <= rd_go;
          cmp_idx_r <= iss_r[IDX_W-1:0];
          if (rd_go) begin
            iss_r <= CNT_W'(iss_r + 1'b1);
          end
          if (search_end) begin
            res_hit_r <= match;
            res_idx_r <= cmp_idx_r;
            state_r   <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            pa_r        <= res_hit_r ? PA_W'({res_idx_r, off_r}) : '0;
            hit_r       <= res_hit_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/inverted_page_table_lookup_core.sv =====
// Inverted page table translator, top level.
// Channels: in_ch (request beats), out_ch (result beats), cfg_ch (search count).
// Load beats (mode 0) write one {pid, vpage} entry at entry_index in the cycle
// they are accepted and produce no result; one load per cycle while idle.
// Translate beats (mode 1) search entries 0 .. entries_in_use-1 in order, one
// table read per cycle through the single read port of the table memory
// (entries_in_use capped at TABLE_ENTRIES), and give one result beat:
// {index, offset} and hit=1 on the first match, else 0. The next request
// beat is taken once the result is in the output register, so in_ch.ready
// stays low while a translation searches and waits for that register.
// The output register holds a result while out_ch.ready is low; a following
// load is still accepted, a following translation searches and then waits.
// Reset (rst_n low, synchronous) clears the control state and the search
// count to 0; the table itself is not cleared and must be loaded before use.
// cfg_ch is always ready; write it only while the block is idle.
`default_nettype none

module inverted_page_table_lookup_core #(
  parameter int TABLE_ENTRIES = ipt_pkg::DEF_TABLE_ENTRIES
) (
  input  wire       clk,
  input  wire       rst_n,
  ipt_in_if.sink    in_ch,
  ipt_out_if.source out_ch,
  ipt_cfg_if.sink   cfg_ch
);
  import ipt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // search count register
  logic [CFG_W-1:0] entries_r;

  ipt_mem_ctl_t     mem_ctl;
  logic [IDX_W-1:0] wr_addr;
  ipt_entry_t       wr_data;
  logic [IDX_W-1:0] rd_addr;
  ipt_entry_t       rd_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      entries_r <= cfg_ch.data;
    end
  end

  // search sequencer, loads and result register
  ipt_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .entries_in_use (entries_r),
    .mem_ctl        (mem_ctl),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data)
  );

  // entry storage, registered read data
  ipt_table #(
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk       (clk),
    .ctl       (mem_ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

endmodule

`default_nettype wire

// ===== dv/ipt_lookup_checker.sv =====
// Scoreboard for the inverted page table lookup core: watches the request,
// result and search-count channels, predicts each translation and compares.
// Depends on ipt_pkg and the channel interfaces in ipt_ifs.sv.
`timescale 1ns / 100ps

module ipt_lookup_checker #(
  parameter int TABLE_ENTRIES = ipt_pkg::DEF_TABLE_ENTRIES
) (
  input  wire clk,
  input  wire rst_n,
  ipt_in_if   in_ch,
  ipt_out_if  out_ch,
  ipt_cfg_if  cfg_ch,
  output int  mismatch_count,
  output int  results_due
);
  import ipt_pkg::*;

  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [PA_W-1:0] paddr;
    logic            hit;
  } xlate_result_t;

  ipt_entry_t       shadow_table [TABLE_ENTRIES];
  logic [CFG_W-1:0] search_cnt;
  xlate_result_t    expected_q [$];
  int               fails = 0;
  int               due = 0;

  assign mismatch_count = fails;
  assign results_due    = due;

  // first matching entry among the searched ones wins; count saturates
  function automatic xlate_result_t translate_va(input logic [VA_W-1:0]  va,
                                                 input logic [PID_W-1:0] pid);
    xlate_result_t r;
    int            span;
    int            i;
    r = '0;
    span = (int'(search_cnt) > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(search_cnt);
    for (i = 0; i < span; i++) begin
      if (!r.hit && shadow_table[i].pid == pid &&
          shadow_table[i].vpage == va[VA_W-1:OFF_W]) begin
        r.paddr = PA_W'({i, va[OFF_W-1:0]});
        r.hit   = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fails < PRINT_CAP)
      $display("%0t checker: %s got 0x%0h want 0x%0h", $time, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    xlate_result_t want;
    if (!rst_n) begin
      expected_q.delete();
      search_cnt = '0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result beat",
                          32'({out_ch.hit, out_ch.physical_address}), '0);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.physical_address !== want.paddr)
            report_mismatch("physical_address", 32'(out_ch.physical_address),
                            32'(want.paddr));
          if (out_ch.hit !== want.hit)
            report_mismatch("hit", 32'(out_ch.hit), 32'(want.hit));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.mode == MODE_LOAD) begin
          shadow_table[in_ch.entry_index].pid   = in_ch.entry_pid;
          shadow_table[in_ch.entry_index].vpage = in_ch.entry_vpage;
        end else begin
          expected_q.push_back(translate_va(in_ch.virtual_address, in_ch.current_pid));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready)
        search_cnt = cfg_ch.data;
    end
    due <= expected_q.size();
  end

endmodule

// ===== dv/tb_inverted_page_table_lookup_core.sv =====
// Testbench top for inverted_page_table_lookup_core: reset, directed and
// random beats, search-count phases, random idling and the verdict.
// Depends on ipt_pkg, ipt_ifs.sv, the core and ipt_lookup_checker.
`timescale 1ns / 100ps

module tb_inverted_page_table_lookup_core;
  import ipt_pkg::*;

  localparam int TBL             = DEF_TABLE_ENTRIES;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int SETTLE_CYCLES   = TBL + 8;     // longest search plus margin
  localparam int HOLD_OFF_CYCLES = 400;         // result side blocked this long
  localparam int WATCHDOG_LIMIT  = 3000;        // cycles with no beat at all
  localparam int IDLE_PCT        = 26;

  typedef struct packed {
    logic                mode;
    logic [IDX_IN_W-1:0] entry_index;
    logic [PID_W-1:0]    entry_pid;
    logic [VPAGE_W-1:0]  entry_vpage;
    logic [VA_W-1:0]     virtual_address;
    logic [PID_W-1:0]    current_pid;
  } lookup_req_t;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ipt_in_if  in_ch();
  ipt_out_if out_ch();
  ipt_cfg_if cfg_ch();

  int mismatches;
  int results_due;

  inverted_page_table_lookup_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ipt_lookup_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_ch         (cfg_ch),
    .mismatch_count (mismatches),
    .results_due    (results_due)
  );

  // Stimulus-side mirror of what has been loaded. It only steers stimulus:
  // translations never search a slot that was not loaded first.
  logic [PID_W-1:0]   gen_pid   [TBL];
  logic [VPAGE_W-1:0] gen_vpage [TBL];
  logic [TBL-1:0]     loaded = '0;
  logic [CFG_W-1:0]   cur_cfg = '0;

  int n_loads = 0;
  int n_xlates = 0;
  int n_settings = 0;

  // burst: no idling on either side; stall_asked/stall_taken hand a
  // hold-off request to the result-side process
  bit burst = 1'b0;
  int stall_asked = 0;
  int stall_taken = 0;

  // ---------------------------------------------------------------------
  // Result side: random back-pressure, plus one long hold-off on request.
  // The hold-off is counted here so the sender keeps offering beats and
  // the core fills up (held result + parked search) and blocks its input.
  // ---------------------------------------------------------------------
  initial begin
    forever begin
      if (stall_taken != stall_asked) begin
        stall_taken = stall_taken + 1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= burst || ($urandom_range(0, 99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: any beat on any channel resets it.
  // ---------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results still due",
               quiet_cycles, results_due);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sender: random idle cycles ahead of each beat, then hold until taken.
  // Valid stays high across back-to-back beats.
  // ---------------------------------------------------------------------
  task automatic send_req(input lookup_req_t r);
    while (!burst && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.mode            <= r.mode;
    in_ch.entry_index     <= r.entry_index;
    in_ch.entry_pid       <= r.entry_pid;
    in_ch.entry_vpage     <= r.entry_vpage;
    in_ch.virtual_address <= r.virtual_address;
    in_ch.current_pid     <= r.current_pid;
    do @(posedge clk); while (!in_ch.ready);
    if (r.mode == MODE_LOAD) begin
      loaded[r.entry_index]    = 1'b1;
      gen_pid[r.entry_index]   = r.entry_pid;
      gen_vpage[r.entry_index] = r.entry_vpage;
      n_loads++;
    end else begin
      n_xlates++;
    end
  endtask

  task automatic send_load(input int idx, input logic [PID_W-1:0] pid,
                           input logic [VPAGE_W-1:0] vpage);
    lookup_req_t r;
    r = '0;
    r.mode            = MODE_LOAD;
    r.entry_index     = IDX_IN_W'(idx);
    r.entry_pid       = pid;
    r.entry_vpage     = vpage;
    r.virtual_address = '1;   // ignored on a load
    send_req(r);
  endtask

  task automatic send_xlate(input logic [VA_W-1:0] va, input logic [PID_W-1:0] pid);
    lookup_req_t r;
    r = '0;
    r.mode            = MODE_XLATE;
    r.entry_index     = '1;   // ignored on a translation
    r.virtual_address = va;
    r.current_pid     = pid;
    send_req(r);
  endtask

  // sender stops and waits for every pending result
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  // full idle: results drained, and any trailing search has had time to end
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_search_count(input logic [CFG_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_cfg = v;
    n_settings++;
  endtask

  // Random request. Slots inside the searched span get loaded before any
  // translation may read them; most translations aim at a loaded entry,
  // some with one bit flipped (near miss), some at slots past the span.
  task automatic make_req(output lookup_req_t r);
    int             span;
    int             roll;
    int             pick;
    int             flip;
    int             i;
    logic [TBL-1:0] need;
    r.mode            = MODE_XLATE;
    r.entry_index     = IDX_IN_W'($urandom);
    r.entry_pid       = PID_W'($urandom);
    r.entry_vpage     = VPAGE_W'($urandom);
    r.virtual_address = $urandom;
    r.current_pid     = PID_W'($urandom);
    span = (int'(cur_cfg) > TBL) ? TBL : int'(cur_cfg);
    need = (span == TBL) ? '1 : ((TBL'(1) << span) - 1'b1);
    need = need & ~loaded;
    roll = $urandom_range(0, 99);
    if (need != '0) begin
      r.mode = MODE_LOAD;
      for (i = TBL - 1; i >= 0; i--)
        if (need[i]) r.entry_index = IDX_IN_W'(i);
    end else if (roll < 35) begin
      r.mode = MODE_LOAD;
      case ($urandom_range(0, 4))
        0: begin  // duplicate an existing entry: first match must win
          pick = $urandom_range(0, TBL - 1);
          if (loaded[pick]) begin
            r.entry_pid   = gen_pid[pick];
            r.entry_vpage = gen_vpage[pick];
          end
        end
        1: r.entry_pid = PID_W'($urandom_range(0, 3));
        2: r.entry_vpage = $urandom_range(0, 1) ? '1 : VPAGE_W'($urandom_range(0, 3));
        default: ;
      endcase
    end else if (roll < 45) begin
      pick = $urandom_range(0, TBL - 1);
      if (loaded[pick]) begin
        r.current_pid     = gen_pid[pick];
        r.virtual_address = {gen_vpage[pick], OFF_W'($urandom)};
      end
    end else if (roll < 85 && span > 0) begin
      pick = $urandom_range(0, span - 1);
      r.current_pid     = gen_pid[pick];
      r.virtual_address = {gen_vpage[pick], OFF_W'($urandom)};
      if (roll >= 75) begin
        flip = $urandom_range(0, PID_W + VPAGE_W - 1);
        if (flip < PID_W)
          r.current_pid[flip] = ~r.current_pid[flip];
        else
          r.virtual_address[OFF_W + flip - PID_W] = ~r.virtual_address[OFF_W + flip - PID_W];
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    lookup_req_t      r;
    int               ph;
    int               k;
    logic [CFG_W-1:0] plan [7];

    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.mode            <= MODE_LOAD;
    in_ch.entry_index     <= '0;
    in_ch.entry_pid       <= '0;
    in_ch.entry_vpage     <= '0;
    in_ch.virtual_address <= '0;
    in_ch.current_pid     <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.data           <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: count of zero, every translation misses
    write_search_count('0);
    send_xlate('0, '0);
    send_xlate('1, '1);

    // Directed loads: field extremes, a duplicate of entry 0, two slots at the
    // top of the table that stay outside the span below
    send_load(0, '0, '0);
    send_load(1, '0, '0);
    send_load(2, 16'h1234, 20'hABCDE);
    send_load(3, '1, '1);
    send_load(TBL - 1, '1, '1);
    send_load(TBL - 2, '1, '0);

    settle();
    write_search_count(CFG_W'(4));
    send_xlate(32'h0000_0000, '0);       // hit at entry 0, offset 0: only hit tells it apart
    send_xlate(32'hABCD_EFFF, 16'h1234); // hit at entry 2, top offset
    send_xlate(32'hABCD_E000, 16'h1235); // pid off by one: miss
    send_xlate(32'hFFFF_FFFF, '1);       // all-ones pair, entry 3 found before entry 63
    send_xlate(32'h0000_0FFF, '1);       // only match is past the span: miss

    // Random phases over several search counts; 127 and 65 saturate.
    plan = '{CFG_W'(TBL), CFG_W'(1), '1, '0, CFG_W'(TBL + 1), CFG_W'(17),
             CFG_W'($urandom_range(2, 127))};
    for (ph = 0; ph < 7; ph++) begin
      settle();
      write_search_count(plan[ph]);
      burst = (ph == 1);                 // one long stretch with no idling
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == 2 && k == 40)
          stall_asked = stall_asked + 1; // long result-side hold-off, full searches
        if (ph == 4 && k == ITEMS_PER_PHASE / 2)
          drain_results();               // sender pause until everything is back
        make_req(r);
        send_req(r);
      end
      burst = 1'b0;
    end

    settle();

    $display("run covered %0d loads and %0d translations over %0d search-count settings",
             n_loads, n_xlates, n_settings);
    $display("including counts 0, 1, 64 and saturating ones, a %0d-cycle result hold-off",
             HOLD_OFF_CYCLES);
    if (mismatches == 0 && results_due == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
